### sv/fmibs_pkg.sv
// shared types and constants for the fm-index backward search block
package fmibs_pkg;

    // item kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEQ_LEN = 3'd0,
        CFG_COUNT_A = 3'd1,
        CFG_COUNT_C = 3'd2,
        CFG_COUNT_G = 3'd3,
        CFG_COUNT_T = 3'd4
    } t_cfg_idx;

    // input transaction
    typedef struct packed {
        logic        kind;
        logic [1:0]  base;
        logic [15:0] position;
        logic [15:0] occ_value;
        logic        seed_start;
        logic        seed_end;
    } t_item;

    // result transaction
    typedef struct packed {
        logic [15:0] interval_low;
        logic [15:0] interval_high;
        logic        present;
    } t_result;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP_LOW,
        S_STEP_HIGH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic wr;         // store an occurrence table entry from the input
        logic search;     // take a search base from the input
        logic step_low;   // low bound read data is back, read high bound
        logic step_high;  // high bound read data is back
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic skip;       // seed already finished, no table reads needed
    } t_dp_stat;

endpackage

### sv/fmibs_ctrl.sv
// controller state machine for the fm-index backward search block
module fmibs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_kind,
    input  fmibs_pkg::t_dp_stat i_stat,
    output fmibs_pkg::t_dp_cmd  o_cmd,
    output logic                o_busy
);
    import fmibs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_kind == KIND_SEARCH) && !i_stat.skip) begin
                    n_state = S_STEP_LOW;
                end
            end
            S_STEP_LOW:  n_state = S_STEP_HIGH;
            S_STEP_HIGH: n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.wr     = accept && (i_kind == KIND_WRITE);
                o_cmd.search = accept && (i_kind == KIND_SEARCH);
            end
            S_STEP_LOW:  o_cmd.step_low = 1'b1;
            S_STEP_HIGH: o_cmd.step_high = 1'b1;
            default:     o_busy = 1'b1;
        endcase
    end

endmodule

### sv/fmibs_datapath.sv
// datapath: occurrence table memory, count registers, interval registers
module fmibs_datapath #(
    parameter int unsigned OCC_DEPTH = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fmibs_pkg::t_dp_cmd             i_cmd,
    output fmibs_pkg::t_dp_stat            o_stat,
    input  fmibs_pkg::t_item               i_item,
    input  logic                           i_cfg_we,
    input  logic [fmibs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    output logic                           o_result_valid,
    output fmibs_pkg::t_result             o_result
);
    import fmibs_pkg::*;

    localparam int unsigned MEM_DEPTH = 4 * OCC_DEPTH;
    localparam int MAW = $clog2(MEM_DEPTH);
    localparam logic [MAW-1:0] OFF_C = MAW'(OCC_DEPTH);
    localparam logic [MAW-1:0] OFF_G = MAW'(2 * OCC_DEPTH);
    localparam logic [MAW-1:0] OFF_T = MAW'(3 * OCC_DEPTH);

    // saturating 16-bit add
    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // configuration registers
    logic [15:0] r_seq_len;
    logic [15:0] r_count [0:3];

    // search state
    logic [15:0] r_low;
    logic [15:0] r_high;
    logic        r_done;
    logic [1:0]  r_base;
    logic        r_fin;

    // memory and read data
    logic [15:0] r_mem [0:MEM_DEPTH-1];
    logic [15:0] r_rdata;
    logic        r_rd_ok;

    logic [1:0]     mem_base;
    logic [15:0]    mem_pos;
    logic [MAW-1:0] mem_off;
    logic [MAW-1:0] mem_addr;
    logic           pos_ok;
    logic [15:0]    occ_data;
    logic [15:0]    step_sum;
    logic           skip;

    // result register
    logic    r_out_valid;
    t_result r_out;

    assign skip        = i_item.seed_start ? 1'b0 : r_done;
    assign o_stat.skip = skip;

    // table address: high bound while stepping, else from the input transaction
    always_comb begin
        if (i_cmd.step_low) begin
            mem_base = r_base;
            mem_pos  = r_high;
        end else if (i_item.kind == KIND_WRITE) begin
            mem_base = i_item.base;
            mem_pos  = i_item.position;
        end else begin
            mem_base = i_item.base;
            mem_pos  = i_item.seed_start ? 16'd0 : r_low;
        end
    end

    always_comb begin
        unique case (mem_base)
            2'd0:    mem_off = '0;
            2'd1:    mem_off = OFF_C;
            2'd2:    mem_off = OFF_G;
            2'd3:    mem_off = OFF_T;
            default: mem_off = '0;
        endcase
    end

    assign pos_ok   = 32'(mem_pos) < OCC_DEPTH;
    assign mem_addr = mem_off + MAW'(mem_pos);

    // occurrence table memory, single port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && pos_ok) begin
            r_mem[mem_addr] <= i_item.occ_value;
        end
        r_rdata <= r_mem[mem_addr];
        r_rd_ok <= pos_ok;
    end

    // out of range lookups read zero
    assign occ_data = r_rd_ok ? r_rdata : 16'd0;
    assign step_sum = sat_add(r_count[r_base], occ_data);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len  <= '0;
            r_count[0] <= '0;
            r_count[1] <= '0;
            r_count[2] <= '0;
            r_count[3] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEQ_LEN: r_seq_len  <= i_cfg_data;
                CFG_COUNT_A: r_count[0] <= i_cfg_data;
                CFG_COUNT_C: r_count[1] <= i_cfg_data;
                CFG_COUNT_G: r_count[2] <= i_cfg_data;
                CFG_COUNT_T: r_count[3] <= i_cfg_data;
                default:     r_seq_len  <= r_seq_len;
            endcase
        end
    end

    // interval registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_cmd.search && i_item.seed_start) begin
                r_low  <= '0;
                r_high <= r_seq_len;
                r_done <= 1'b0;
            end
            if (i_cmd.step_low) begin
                r_low <= step_sum;
            end
            if (i_cmd.step_high) begin
                r_high <= step_sum;
                r_done <= r_low >= step_sum;
            end
        end
    end

    // per-base transaction fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_base <= i_item.base;
            r_fin  <= i_item.seed_end;
        end
    end

    // result register, one cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.search && skip && i_item.seed_end)
                        || (i_cmd.step_high && r_fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_high) begin
            r_out.interval_low  <= r_low;
            r_out.interval_high <= step_sum;
            r_out.present       <= r_low < step_sum;
        end else if (i_cmd.search) begin
            r_out.interval_low  <= r_low;
            r_out.interval_high <= r_high;
            r_out.present       <= r_low < r_high;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

### sv/fm_index_backward_search.sv
// fm-index backward search: one base per search transaction, occurrence table writes
// busy: a search base whose seed is live holds o_busy through S_STEP_LOW and S_STEP_HIGH
//   (two reads of the single-port occurrence table); its result strobes in the cycle after that
// throughput: one table write or finished-seed base per cycle, but none while a search steps
// reset: synchronous active low, clears interval, done flag, counts and seq_len; the table
//   itself is not cleared. the receiver cannot stall results
module fm_index_backward_search #(
    parameter int unsigned OCC_DEPTH = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  fmibs_pkg::t_item                i_item,
    output logic                            o_result_valid,
    output fmibs_pkg::t_result              o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fmibs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import fmibs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    // controller
    fmibs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_kind  (i_item.kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // datapath
    fmibs_datapath #(
        .OCC_DEPTH (OCC_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

`ifndef SYNTHESIS
    // a search step is busy through S_STEP_LOW and S_STEP_HIGH, then goes idle
    a_busy_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |=> o_busy)
        else $error("busy dropped after one cycle");

    a_busy_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy && $past(o_busy)) |=> !o_busy)
        else $error("busy held longer than two cycles");

    // a table write neither stalls nor produces a result
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_item.kind == KIND_WRITE)) |=> (!o_busy && !o_result_valid))
        else $error("table write caused busy or a result");
`endif

endmodule

### sim/fm_index_backward_search_tb.sv
// self-checking testbench for the fm-index backward search block
module fm_index_backward_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmibs_pkg::*;

    localparam int unsigned OCC_DEPTH = 65536;
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int N_PHASES      = 4;
    localparam int PHASE_ITEMS   = 420;
    localparam int NOISE_PCT     = 15;
    localparam int MAX_GAP       = 6;
    localparam int MAX_REPORTS   = 10;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int SENTINEL      = 4;
    localparam int MAX_TEXT      = 40;
    localparam int PHASE_IDLE [N_PHASES] = '{0, 68, 8, 0};

    // register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // nucleotide encoding
    typedef enum logic [1:0] {
        BASE_A,
        BASE_C,
        BASE_G,
        BASE_T
    } t_base;

    // directed stimulus row: register write or one transaction
    typedef enum logic {
        ROW_REG,
        ROW_TX
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] cfg_index;
        logic [15:0]          cfg_data;
        t_item                item;
        logic                 checked_here;  // expected interval typed into the row
        t_result              result;
    } t_row;

    localparam t_item   NO_ITEM   = '0;
    localparam t_result NO_RESULT = '0;
    localparam int N_DIRECTED = 23;

    localparam t_row DIRECTED [N_DIRECTED] = '{
        // write with seed flags set, which a write ignores
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_WRITE, BASE_A, 16'h0000, 16'h0000, 1'b1, 1'b1}, 1'b0, NO_RESULT},
        // base with no seed start right after reset: interval [0, 0)
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_SEARCH, BASE_A, 16'h0000, 16'h0000, 1'b0, 1'b1},
          1'b1, '{16'd0, 16'd0, 1'b0}},
        '{ROW_REG, CFG_SEQ_LEN, 16'hFFFF, NO_ITEM, 1'b0, NO_RESULT},
        '{ROW_REG, CFG_COUNT_A, 16'hFFFF, NO_ITEM, 1'b0, NO_RESULT},
        '{ROW_REG, CFG_COUNT_C, 16'h0000, NO_ITEM, 1'b0, NO_RESULT},
        '{ROW_REG, CFG_COUNT_G, 16'h0001, NO_ITEM, 1'b0, NO_RESULT},
        '{ROW_REG, CFG_COUNT_T, 16'd100, NO_ITEM, 1'b0, NO_RESULT},
        // unused register index must change nothing
        '{ROW_REG, CFG_SPARE, 16'h1234, NO_ITEM, 1'b0, NO_RESULT},
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_WRITE, BASE_A, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b0, NO_RESULT},
        // both bounds saturate at the top
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_SEARCH, BASE_A, 16'h0000, 16'h0000, 1'b1, 1'b1},
          1'b1, '{16'hFFFF, 16'hFFFF, 1'b0}},
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_WRITE, BASE_C, 16'h0000, 16'h0000, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_WRITE, BASE_C, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        // full-width interval
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_SEARCH, BASE_C, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1},
          1'b1, '{16'h0000, 16'hFFFF, 1'b1}},
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_WRITE, BASE_T, 16'h0000, 16'h0007, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_WRITE, BASE_T, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        // two-base seed, high bound saturates
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_SEARCH, BASE_T, 16'hAAAA, 16'h5555, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_WRITE, BASE_T, 16'd107, 16'h5555, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_SEARCH, BASE_T, 16'h5555, 16'hAAAA, 1'b0, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_WRITE, BASE_G, 16'h0000, 16'h0005, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_WRITE, BASE_G, 16'hFFFF, 16'h0005, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        // seed runs empty on its first base, later bases leave it alone
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_SEARCH, BASE_G, 16'h0000, 16'h0000, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_SEARCH, BASE_A, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{ROW_TX, CFG_SEQ_LEN, 16'h0,
          '{KIND_SEARCH, BASE_C, 16'h0000, 16'h0000, 1'b0, 1'b1},
          1'b1, '{16'd6, 16'd6, 1'b0}}
    };

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_start     = 1'b0;
    t_item   i_item      = '0;
    logic    i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data  = '0;
    logic    o_busy;
    logic    o_result_valid;
    t_result o_result;
    logic    o_cfg_ready;

    // predicted block state
    logic [15:0] occ_model  [4][OCC_DEPTH];
    bit          occ_loaded [4][OCC_DEPTH];
    logic [15:0] seq_len_cfg = '0;
    logic [15:0] base_count [4] = '{default: '0};
    logic [15:0] cur_low     = '0;
    logic [15:0] cur_high    = '0;
    bit          seed_over   = 1'b0;

    t_result expected_intervals [$];
    int      mismatch_count = 0;
    int      items_taken    = 0;

    fm_index_backward_search #(
        .OCC_DEPTH(OCC_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_item        (i_item),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // one transaction through the predictor; returns 1 when it yields an interval
    function automatic bit backward_step(input t_item it, output t_result r);
        logic [15:0] occ_lo;
        logic [15:0] occ_hi;
        r = '0;
        if (it.kind == KIND_WRITE) begin
            occ_model[it.base][it.position]  = it.occ_value;
            occ_loaded[it.base][it.position] = 1'b1;
            return 1'b0;
        end
        if (it.seed_start) begin
            cur_low   = '0;
            cur_high  = seq_len_cfg;
            seed_over = 1'b0;
        end
        if (!seed_over) begin
            occ_lo    = occ_model[it.base][cur_low];
            occ_hi    = occ_model[it.base][cur_high];
            cur_low   = sat_sum(base_count[it.base], occ_lo);
            cur_high  = sat_sum(base_count[it.base], occ_hi);
            seed_over = (cur_low >= cur_high);
        end
        r.interval_low  = cur_low;
        r.interval_high = cur_high;
        r.present       = (cur_low < cur_high);
        return it.seed_end;
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.kind       = 1'($urandom);
        it.base       = 2'($urandom);
        it.position   = 16'($urandom);
        it.occ_value  = 16'($urandom);
        it.seed_start = 1'($urandom);
        it.seed_end   = 1'($urandom);
        return it;
    endfunction

    function automatic void log_mismatch(string what, t_result want, t_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s: expected low %0d high %0d present %0b, got low %0d high %0d present %0b",
                     what, want.interval_low, want.interval_high, want.present,
                     got.interval_low, got.interval_high, got.present);
        end
    endfunction

    // compare every result strobe with the oldest expected interval
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_result_valid !== 1'b0) begin
            if (expected_intervals.size() == 0) begin
                log_mismatch("unexpected result", NO_RESULT, o_result);
            end else begin
                want = expected_intervals.pop_front();
                if (o_result.interval_low !== want.interval_low ||
                    o_result.interval_high !== want.interval_high ||
                    o_result.present !== want.present) begin
                    log_mismatch("interval mismatch", want, o_result);
                end
            end
        end
    end

    task automatic sender_idle(int cycles);
        i_start <= 1'b0;
        i_item  <= random_item();
        repeat (cycles) @(posedge i_clk);
    endtask

    // present one transaction and hold it until the block takes it
    task automatic issue(t_item it, bit fixed, t_result fixed_res, int idle_pct);
        t_result r;
        bit      emits;
        i_item  <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        items_taken++;
        emits = backward_step(it, r);
        if (emits) expected_intervals = {expected_intervals, fixed ? fixed_res : r};
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) sender_idle($urandom_range(1, MAX_GAP));
    endtask

    // load any table entry a search base would read before it was ever written
    task automatic submit(t_item it, bit fixed, t_result fixed_res, int idle_pct);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] p;
        t_item       wr;
        if (it.kind == KIND_SEARCH && (it.seed_start || !seed_over)) begin
            lo = it.seed_start ? 16'h0 : cur_low;
            hi = it.seed_start ? seq_len_cfg : cur_high;
            for (int k = 0; k < 2; k++) begin
                p = (k == 0) ? lo : hi;
                if (!occ_loaded[it.base][p]) begin
                    wr           = random_item();
                    wr.kind      = KIND_WRITE;
                    wr.base      = it.base;
                    wr.position  = p;
                    wr.occ_value = $urandom_range(1, 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, seq_len_cfg));
                    issue(wr, 1'b0, NO_RESULT, idle_pct);
                end
            end
        end
        issue(it, fixed, fixed_res, idle_pct);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_SEQ_LEN: seq_len_cfg = val;
            CFG_COUNT_A: base_count[BASE_A] = val;
            CFG_COUNT_C: base_count[BASE_C] = val;
            CFG_COUNT_G: base_count[BASE_G] = val;
            CFG_COUNT_T: base_count[BASE_T] = val;
            default: ;
        endcase
    endtask

    // stop sending, wait for every expected interval and for the block to go idle
    task automatic settle();
        i_start <= 1'b0;
        while (expected_intervals.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
    endtask

    // watchdog
    initial begin
        #TIMEOUT_NS;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        bit          prev_reg;
        int          sym [MAX_TEXT];
        int          totals [4];
        int          run [4];
        logic [15:0] reg_val [5];
        t_item       it;
        t_item       wr;
        int          len;
        int          sentinel;
        int          idle;
        int          target;
        int          seed_len;

        prev_reg = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].kind == ROW_REG) begin
                if (!prev_reg) settle();
                write_register(DIRECTED[r].cfg_index, DIRECTED[r].cfg_data);
            end else begin
                if (prev_reg) i_cfg_valid <= 1'b0;
                submit(DIRECTED[r].item, DIRECTED[r].checked_here, DIRECTED[r].result, 0);
            end
            prev_reg = (DIRECTED[r].kind == ROW_REG);
        end

        // random phases, each with its own register setting and idling
        for (int ph = 0; ph < N_PHASES; ph++) begin
            idle = PHASE_IDLE[ph];
            settle();
            if (ph < N_PHASES - 1) begin
                // random text with one sentinel, counts as an fm-index would hold them
                len      = $urandom_range(7, 33);
                sentinel = $urandom_range(0, len - 1);
                totals   = '{default: 0};
                for (int i = 0; i < len; i++) begin
                    sym[i] = (i == sentinel) ? SENTINEL : int'($urandom_range(0, 3));
                    if (sym[i] != SENTINEL) totals[sym[i]]++;
                end
                reg_val[CFG_SEQ_LEN] = 16'(len);
                reg_val[CFG_COUNT_A] = 16'(1);
                reg_val[CFG_COUNT_C] = 16'(1 + totals[BASE_A]);
                reg_val[CFG_COUNT_G] = 16'(1 + totals[BASE_A] + totals[BASE_C]);
                reg_val[CFG_COUNT_T] = 16'(1 + totals[BASE_A] + totals[BASE_C] + totals[BASE_G]);
            end else begin
                // arbitrary setting with frequent extremes
                foreach (reg_val[r]) begin
                    if ($urandom_range(3, 0) == 0)
                        reg_val[r] = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
                    else
                        reg_val[r] = 16'($urandom);
                end
            end
            if ($urandom_range(1, 0) == 1)
                write_register(CFG_IDX_W'($urandom_range(int'(CFG_COUNT_T) + 1, int'(CFG_SPARE))),
                               16'($urandom));
            for (int r = int'(CFG_SEQ_LEN); r <= int'(CFG_COUNT_T); r++)
                write_register(CFG_IDX_W'(r), reg_val[r]);
            i_cfg_valid <= 1'b0;

            // occurrence table of the text, positions 0 to len
            if (ph < N_PHASES - 1) begin
                run = '{default: 0};
                for (int i = 0; i <= len; i++) begin
                    for (int b = 0; b < 4; b++) begin
                        wr           = random_item();
                        wr.kind      = KIND_WRITE;
                        wr.base      = 2'(b);
                        wr.position  = 16'(i);
                        wr.occ_value = 16'(run[b]);
                        submit(wr, 1'b0, NO_RESULT, idle);
                    end
                    if (i < len && sym[i] != SENTINEL) run[sym[i]]++;
                end
            end

            // mostly well-formed seeds, some arbitrary transactions
            target = items_taken + PHASE_ITEMS;
            while (items_taken < target) begin
                if ($urandom_range(99) < NOISE_PCT) begin
                    submit(random_item(), 1'b0, NO_RESULT, idle);
                end else begin
                    seed_len = $urandom_range(1, 6);
                    for (int j = 0; j < seed_len; j++) begin
                        it            = random_item();
                        it.kind       = KIND_SEARCH;
                        it.seed_start = (j == 0);
                        it.seed_end   = (j == seed_len - 1);
                        submit(it, 1'b0, NO_RESULT, idle);
                    end
                end
                if ($urandom_range(99) < 2) settle();
            end
        end

        settle();
        if (mismatch_count == 0 && expected_intervals.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
